FILE: rtl/core/rtpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpr_pkg
// Shared types and constants for the tile palette remap block.
// ----------------------------------------------------------------------------
package rtpr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned LIT_W   = 7;
	localparam int unsigned WIDTH_W = 6;
	localparam int unsigned ROW_W   = 5;

	// input word kinds
	localparam logic MODE_TABLE_WRITE = 1'b0;
	localparam logic MODE_FRAME_BYTE  = 1'b1;

	// per-word flags from the run controller
	typedef struct packed {
		logic map_pixel;
		logic is_control;
		logic row_end;
		logic frame_end;
	} rtpr_flags_t;

endpackage

FILE: rtl/core/rtpr_palette_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpr_palette_mem
// 256 x 8 palette table, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtpr_palette_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [rtpr_pkg::INDEX_W-1:0] waddr,
	input  logic [rtpr_pkg::BYTE_W-1:0]  wdata,
	input  logic                      re,
	input  logic [rtpr_pkg::INDEX_W-1:0] raddr,
	output logic [rtpr_pkg::BYTE_W-1:0]  rdata
);
	import rtpr_pkg::*;

	localparam int unsigned DEPTH = 1 << INDEX_W;

	logic [BYTE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/rtpr_run_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpr_run_ctrl
// Run-length decode and row/frame position tracking for transparent tiles.
// ----------------------------------------------------------------------------
module rtpr_run_ctrl #(
	parameter int unsigned FRAME_WIDTH  = 32,
	parameter int unsigned FRAME_HEIGHT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       transparent,
	input  logic [rtpr_pkg::BYTE_W-1:0] data,
	output rtpr_pkg::rtpr_flags_t      flags
);
	import rtpr_pkg::*;

	localparam logic [WIDTH_W-1:0] WIDTH_RELOAD = WIDTH_W'(FRAME_WIDTH);
	localparam logic [ROW_W:0]     HEIGHT_LIM   = (ROW_W + 1)'(FRAME_HEIGHT);

	logic [LIT_W-1:0]   literal_q, literal_n;
	logic [WIDTH_W-1:0] width_q, width_n;
	logic [ROW_W-1:0]   row_q, row_n;

	logic [WIDTH_W-1:0] len;
	logic [BYTE_W-1:0]  skip;
	logic [ROW_W:0]     row_inc;

	// decode of one frame word
	always_comb begin
		flags     = '0;
		literal_n = literal_q;
		width_n   = width_q;
		row_n     = row_q;
		len       = '0;
		skip      = BYTE_W'(-data);
		row_inc   = {1'b0, row_q} + (ROW_W + 1)'(1);
		if (!transparent) begin
			flags.map_pixel = 1'b1;
		end else begin
			if (literal_q != '0) begin
				flags.map_pixel = 1'b1;
				literal_n       = literal_q - LIT_W'(1);
			end else begin
				flags.is_control = 1'b1;
				if (data != '0 && !data[BYTE_W-1]) begin
					// literal run, clamped to the row
					if (data[LIT_W-1:0] > {1'b0, width_q}) begin
						len = width_q;
					end else begin
						len = data[WIDTH_W-1:0];
					end
					literal_n = {1'b0, len};
					width_n   = width_q - len;
				end else if (data[BYTE_W-1]) begin
					// skip run, clamped to the row
					if (skip > {2'b00, width_q}) begin
						len = width_q;
					end else begin
						len = skip[WIDTH_W-1:0];
					end
					width_n = width_q - len;
				end
			end
			// row and frame wrap
			if (literal_n == '0 && width_n == '0) begin
				flags.row_end = 1'b1;
				width_n       = WIDTH_RELOAD;
				if (row_inc >= HEIGHT_LIM) begin
					flags.frame_end = 1'b1;
					row_n           = '0;
				end else begin
					row_n = row_inc[ROW_W-1:0];
				end
			end
		end
	end

	// counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			literal_q <= '0;
			width_q   <= WIDTH_RELOAD;
			row_q     <= '0;
		end else if (step && transparent) begin
			literal_q <= literal_n;
			width_q   <= width_n;
			row_q     <= row_n;
		end
	end

endmodule

FILE: rtl/core/rle_tile_palette_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_tile_palette_remap
// Palette remap of tile bytes with optional run-length transparent decode.
// ----------------------------------------------------------------------------
// path: a frame word passes the read stage and then the output register
// throughput: one word per cycle unless stalled, set by the single read port
// a two-entry pipe (read stage plus output register) keeps input flowing
// while a result waits on a stalled output
// reset clears the literal and row counters, reloads the width counter and
// clears mode register and valid flags; palette contents undefined until written
module rle_tile_palette_remap #(
	parameter int unsigned FRAME_WIDTH  = 32,
	parameter int unsigned FRAME_HEIGHT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [rtpr_pkg::INDEX_W-1:0] table_index,
	input  logic [rtpr_pkg::BYTE_W-1:0]  table_value,
	input  logic [rtpr_pkg::BYTE_W-1:0]  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rtpr_pkg::BYTE_W-1:0]  out_byte,
	output logic                        is_control,
	output logic                        row_end,
	output logic                        frame_end
);
	import rtpr_pkg::*;

	logic              transparent_q;
	logic              accept, frame_word, advance;
	rtpr_flags_t       flags;
	logic [BYTE_W-1:0] rdata;

	logic              valid_s1, valid_s2;
	rtpr_flags_t       flags_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [BYTE_W-1:0] byte_s2;
	logic              ctl_s2, rend_s2, fend_s2;

	// mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			transparent_q <= cfg_data;
		end
	end

	// input handshake
	assign advance    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance;
	assign accept     = in_valid && !in_stall;
	assign frame_word = accept && (mode == MODE_FRAME_BYTE);

	// palette table
	rtpr_palette_mem u_mem (
		.clk   (clk),
		.we    (accept && (mode == MODE_TABLE_WRITE)),
		.waddr (table_index),
		.wdata (table_value),
		.re    (frame_word),
		.raddr (data_byte),
		.rdata (rdata)
	);

	// run and position control
	rtpr_run_ctrl #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (frame_word),
		.transparent (transparent_q),
		.data        (data_byte),
		.flags       (flags)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (mode == MODE_FRAME_BYTE);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_word) begin
			flags_s1 <= flags;
			data_s1  <= data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= flags_s1.map_pixel ? rdata : data_s1;
			ctl_s2  <= flags_s1.is_control;
			rend_s2 <= flags_s1.row_end;
			fend_s2 <= flags_s1.frame_end;
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte   = byte_s2;
	assign is_control = ctl_s2;
	assign row_end    = rend_s2;
	assign frame_end  = fend_s2;

`ifndef SYNTHESIS
	// a frame end is always also a row end
	a_frame_implies_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame_end without row_end");

	// input only stalls behind a held read stage
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipe");

	// a table write never produces a result word
	a_table_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_TABLE_WRITE) |=> !valid_s1)
		else $error("table write created a result");

	// a mapped pixel never carries the control flag
	a_pixel_not_control: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(flags_s1.map_pixel && flags_s1.is_control))
		else $error("word flagged both pixel and control");
`endif

endmodule
